// File: hw/rtl/lkv_pkg.sv
// Shared constants, codes and structs of the LRU key-value cache.
package lkv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  // Which cell an update command lands on.
  typedef enum logic [1:0] {
    TGT_NONE,
    TGT_MATCH,
    TGT_FREE,
    TGT_OLDEST
  } tgt_sel_t;

  // Search packet handed from cell to cell.
  typedef struct packed {
    logic             vld;
    logic             found;
    logic [IDX_W-1:0] rank;
    logic [VAL_W-1:0] value;
  } link_t;

  // Update command broadcast to all cells.
  typedef struct packed {
    logic             apply;
    tgt_sel_t         sel;
    logic [CNT_W-1:0] ref_rank;
    logic [IDX_W-1:0] slot;
    logic             wr_key;
    logic             wr_val;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cmd_t;

endpackage

// File: hw/rtl/lkv_if.sv
// Request and response channel interfaces of the LRU key-value cache.
interface lkv_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink (input valid, input opcode, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] read_value;
  logic               evicted;

  modport source (output valid, output hit, output read_value, output evicted, input ready);
  modport sink (input valid, input hit, input read_value, input evicted, output ready);
endinterface

// File: hw/rtl/lkv_cell.sv
// One cache entry: key, value, valid mark and recency rank, plus a search link stage.
module lkv_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [lkv_pkg::IDX_W-1:0]  cell_id,
  input  lkv_pkg::cmd_t              cmd,
  input  lkv_pkg::link_t             link_in,
  output lkv_pkg::link_t             link_out
);

  logic                      valid;
  logic [lkv_pkg::IDX_W-1:0] rank;
  logic [lkv_pkg::KEY_W-1:0] key;
  logic [lkv_pkg::VAL_W-1:0] value;

  logic                      link_vld;
  logic                      link_found;
  logic [lkv_pkg::IDX_W-1:0] link_rank;
  logic [lkv_pkg::VAL_W-1:0] link_value;

  logic match;
  logic is_tgt;
  logic age;

  assign match = valid && (key == cmd.key);

  always_comb begin
    case (cmd.sel)
      lkv_pkg::TGT_MATCH:  is_tgt = match;
      lkv_pkg::TGT_FREE:   is_tgt = (cell_id == cmd.slot);
      lkv_pkg::TGT_OLDEST: is_tgt = valid && (lkv_pkg::CNT_W'(rank) == cmd.ref_rank);
      default:             is_tgt = 1'b0;
    endcase
  end

  // Entries more recent than the reference rank age by one.
  assign age = valid && !is_tgt && (lkv_pkg::CNT_W'(rank) < cmd.ref_rank);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (cmd.apply) begin
      if (is_tgt) begin
        valid <= 1'b1;
        rank  <= '0;
      end else if (age) begin
        rank <= rank + lkv_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && is_tgt) begin
      if (cmd.wr_key) begin
        key <= cmd.key;
      end
      if (cmd.wr_val) begin
        value <= cmd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= 1'b0;
    end else begin
      link_vld <= link_in.vld;
    end
  end

  // Merge this entry into the passing search packet on a key match.
  always_ff @(posedge clk) begin
    if (link_in.vld && match) begin
      link_found <= 1'b1;
      link_rank  <= rank;
      link_value <= value;
    end else begin
      link_found <= link_in.found;
      link_rank  <= link_in.rank;
      link_value <= link_in.value;
    end
  end

  assign link_out.vld   = link_vld;
  assign link_out.found = link_found;
  assign link_out.rank  = link_rank;
  assign link_out.value = link_value;

endmodule

// File: hw/rtl/lkv_ctl.sv
// Sequencer: request capture, search launch, update decision and response register.
module lkv_ctl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [lkv_pkg::CAP_W-1:0]  cfg_wr_data,
  lkv_req_if.sink                    req,
  lkv_rsp_if.source                  rsp,
  output lkv_pkg::link_t             head,
  input  lkv_pkg::link_t             tail,
  output lkv_pkg::cmd_t              cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [lkv_pkg::CAP_W-1:0] cap;
  logic [lkv_pkg::CNT_W-1:0] filled;
  logic                      inject;

  logic                      op;
  logic [lkv_pkg::KEY_W-1:0] key;
  logic [lkv_pkg::VAL_W-1:0] value;

  logic                      hit_found;
  logic [lkv_pkg::IDX_W-1:0] hit_rank;
  logic [lkv_pkg::VAL_W-1:0] hit_value;

  logic                      rsp_valid;
  logic                      rsp_hit;
  logic [lkv_pkg::VAL_W-1:0] rsp_value;
  logic                      rsp_evicted;

  logic accept;
  logic out_free;
  logic room;
  logic finish;
  logic evict;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign out_free = !rsp_valid || rsp.ready;
  assign finish   = (state == ST_UPDATE) && out_free;

  // Capacity zero acts as one; anything above the entry count acts as full size.
  assign room = (filled < lkv_pkg::CNT_W'(lkv_pkg::MAX_ENTRIES)) &&
                ((cap == '0) ? (filled == '0)
                             : (lkv_pkg::CMP_W'(filled) < lkv_pkg::CMP_W'(cap)));

  assign evict = (op == lkv_pkg::OP_SET) && !hit_found && !room;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_SEARCH;
      ST_SEARCH: if (tail.vld) state_next = ST_UPDATE;
      ST_UPDATE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      inject <= 1'b0;
      cap    <= lkv_pkg::CAP_RESET;
      filled <= '0;
    end else begin
      state  <= state_next;
      inject <= accept;
      if (cfg_wr_en) begin
        cap <= cfg_wr_data;
      end
      if (finish && (op == lkv_pkg::OP_SET) && !hit_found && room) begin
        filled <= filled + lkv_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= req.opcode;
      key   <= req.key;
      value <= req.value;
    end
    if (tail.vld) begin
      hit_found <= tail.found;
      hit_rank  <= tail.rank;
      hit_value <= tail.value;
    end
  end

  assign head.vld   = inject;
  assign head.found = 1'b0;
  assign head.rank  = '0;
  assign head.value = '0;

  always_comb begin
    cmd.apply    = finish;
    cmd.sel      = lkv_pkg::TGT_NONE;
    cmd.ref_rank = '0;
    cmd.slot     = filled[lkv_pkg::IDX_W-1:0];
    cmd.wr_key   = 1'b0;
    cmd.wr_val   = 1'b0;
    cmd.key      = key;
    cmd.value    = value;
    if (hit_found) begin
      cmd.sel      = lkv_pkg::TGT_MATCH;
      cmd.ref_rank = lkv_pkg::CNT_W'(hit_rank);
      cmd.wr_val   = (op == lkv_pkg::OP_SET);
    end else if (op == lkv_pkg::OP_SET) begin
      cmd.wr_key = 1'b1;
      cmd.wr_val = 1'b1;
      if (room) begin
        // New entry goes to the next free cell; every valid entry ages.
        cmd.sel      = lkv_pkg::TGT_FREE;
        cmd.ref_rank = filled;
      end else begin
        // Oldest entry holds the highest rank in use.
        cmd.sel      = lkv_pkg::TGT_OLDEST;
        cmd.ref_rank = filled - lkv_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp_hit     <= hit_found;
      rsp_evicted <= evict;
      if (op == lkv_pkg::OP_SET) begin
        rsp_value <= '0;
      end else if (hit_found) begin
        rsp_value <= hit_value;
      end else begin
        rsp_value <= '1;
      end
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.read_value = rsp_value;
  assign rsp.evicted    = rsp_evicted;

  a_tail_in_search: assert property (@(posedge clk) disable iff (rst)
    tail.vld |-> (state == ST_SEARCH))
    else $error("search packet left the chain outside the search phase");

  a_finish_loads_rsp: assert property (@(posedge clk) disable iff (rst)
    finish |=> rsp_valid)
    else $error("update did not produce a response");

  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= lkv_pkg::CNT_W'(lkv_pkg::MAX_ENTRIES))
    else $error("fill count beyond entry count");

  a_rsp_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_UPDATE))
    else $error("response raised without an update");

endmodule

// File: hw/rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache: sequencer and chain of entry cells.
//
//   channel  dir   handshake          payload
//   req      in    req.valid/ready    opcode, key, value
//   rsp      out   rsp.valid/ready    hit, read_value, evicted
//   cfg      in    cfg_wr_en          cfg_wr_data (capacity_in_use)
//
// A transaction steps through idle to accept, the search packet walking the cell chain one
// cell per cycle, a latch of the packet at the chain end, and an update of all cells.
// Synchronous reset clears every valid mark and rank and restores capacity 16.
// The next request is taken while a response waits; a stalled rsp holds only the
// update step of the following transaction.
module lru_key_value_cache (
  input  logic                      clk,
  input  logic                      rst,
  lkv_req_if.sink                   req,
  lkv_rsp_if.source                 rsp,
  input  logic                      cfg_wr_en,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_wr_data
);

  lkv_pkg::link_t chain [lkv_pkg::MAX_ENTRIES+1];
  lkv_pkg::cmd_t  cmd;

  lkv_ctl u_ctl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .rsp         (rsp),
    .head        (chain[0]),
    .tail        (chain[lkv_pkg::MAX_ENTRIES]),
    .cmd         (cmd)
  );

  for (genvar i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin : g_cell
    lkv_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_id  (lkv_pkg::IDX_W'(i)),
      .cmd      (cmd),
      .link_in  (chain[i]),
      .link_out (chain[i+1])
    );
  end

endmodule

// File: sim/lru_cache_checker.sv
// Cache predictor and response checker for the LRU key-value cache testbench.
`timescale 1ns / 100ps
module lru_cache_checker (
  input  logic                      clk,
  input  logic                      rst,
  lkv_req_if                        req,
  lkv_rsp_if                        rsp,
  input  logic                      cfg_wr_en,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_wr_data,
  output int                        fail_count,
  output int                        pending
);

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
  } cache_rsp_t;

  logic                      slot_used [lkv_pkg::MAX_ENTRIES];
  logic [lkv_pkg::KEY_W-1:0] slot_key  [lkv_pkg::MAX_ENTRIES];
  logic [lkv_pkg::VAL_W-1:0] slot_val  [lkv_pkg::MAX_ENTRIES];
  int unsigned               slot_age  [lkv_pkg::MAX_ENTRIES];
  int unsigned               fill_cnt;
  logic [lkv_pkg::CAP_W-1:0] cap_reg;
  cache_rsp_t                due_responses[$];

  // Age every entry newer than idx by one, then make idx the newest.
  function automatic void make_newest(input int idx);
    int unsigned old_age;
    old_age = slot_age[idx];
    for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
      if (slot_used[i] && i != idx && slot_age[i] < old_age)
        slot_age[i]++;
    slot_age[idx] = 0;
  endfunction

  function automatic cache_rsp_t apply_cache_op(input logic op,
                                                input logic [lkv_pkg::KEY_W-1:0] k,
                                                input logic [lkv_pkg::VAL_W-1:0] v);
    cache_rsp_t  res;
    int unsigned limit;
    int          match;
    int          target;
    res   = '0;
    limit = int'(cap_reg);
    match = -1;
    if (limit < 1) limit = 1;
    if (limit > lkv_pkg::MAX_ENTRIES) limit = lkv_pkg::MAX_ENTRIES;
    for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
      if (match < 0 && slot_used[i] && slot_key[i] == k)
        match = i;
    res.hit = (match >= 0);
    if (op == lkv_pkg::OP_GET) begin
      if (match >= 0) begin
        res.read_value = slot_val[match];
        make_newest(match);
      end else begin
        res.read_value = '1;
      end
    end else if (match >= 0) begin
      slot_val[match] = v;
      make_newest(match);
    end else if (fill_cnt < limit) begin
      // fill the lowest free entry
      target = -1;
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
        if (target < 0 && !slot_used[i])
          target = i;
      if (target >= 0) begin
        for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
          if (slot_used[i])
            slot_age[i]++;
        slot_used[target] = 1'b1;
        slot_key[target]  = k;
        slot_val[target]  = v;
        slot_age[target]  = 0;
        fill_cnt++;
      end
    end else begin
      // replace the oldest entry
      target = -1;
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
        if (slot_used[i] && (target < 0 || slot_age[i] > slot_age[target]))
          target = i;
      if (target >= 0) begin
        slot_key[target] = k;
        slot_val[target] = v;
        make_newest(target);
        res.evicted = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ERROR %s: got %h expected %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    cache_rsp_t want;
    if (rst) begin
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
        slot_used[i] = 1'b0;
        slot_age[i]  = 0;
      end
      fill_cnt   = 0;
      cap_reg    = lkv_pkg::CAP_RESET;
      fail_count = 0;
      due_responses.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (due_responses.size() == 0) begin
          report_mismatch("response with no transaction outstanding", rsp.read_value, '0);
        end else begin
          want = due_responses.pop_front();
          if (rsp.hit !== want.hit)
            report_mismatch("hit", 32'(rsp.hit), 32'(want.hit));
          if (rsp.read_value !== want.read_value)
            report_mismatch("read_value", rsp.read_value, want.read_value);
          if (rsp.evicted !== want.evicted)
            report_mismatch("evicted", 32'(rsp.evicted), 32'(want.evicted));
        end
      end
      if (cfg_wr_en)
        cap_reg = cfg_wr_data;
      if (req.valid && req.ready)
        due_responses.push_back(apply_cache_op(req.opcode, req.key, req.value));
    end
    pending = due_responses.size();
  end

endmodule

// File: sim/tb_lru_key_value_cache.sv
// Stimulus, clocking and verdict for the LRU key-value cache testbench.
`timescale 1ns / 100ps
module tb_lru_key_value_cache;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_wr_en;
  logic [lkv_pkg::CAP_W-1:0] cfg_wr_data;
  int                        fail_count;
  int                        pending;
  int                        cycle_count = 0;
  int                        req_gap_pct = 0;
  int                        rsp_stall_pct = 0;
  logic                      hold_request = 1'b0;

  lkv_req_if req_ch ();
  lkv_rsp_if rsp_ch ();

  lru_key_value_cache dut (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  lru_cache_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lru_key_value_cache test failed");
      $finish;
    end
  end

  // Response side: random stalls, plus one long hold-off on request.
  initial begin
    int   hold_left;
    logic hold_served;
    hold_left   = 0;
    hold_served = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_served) begin
        hold_left   = HOLD_CYCLES;
        hold_served = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(input logic op, input logic [lkv_pkg::KEY_W-1:0] k,
                      input logic [lkv_pkg::VAL_W-1:0] v);
    while ($urandom_range(99) < req_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= op;
    req_ch.key    <= k;
    req_ch.value  <= v;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Drain all outstanding transactions, then write the capacity register.
  task automatic set_capacity(input logic [lkv_pkg::CAP_W-1:0] cap);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(input logic [lkv_pkg::CAP_W-1:0] cap, input int mode,
                           input int count, input logic start_hold);
    logic [lkv_pkg::KEY_W-1:0] pool[$];
    int                        eff_cap;
    logic [lkv_pkg::KEY_W-1:0] k;
    set_capacity(cap);
    // start the long receiver hold only once the sender is free to keep offering
    if (start_hold)
      hold_request <= 1'b1;
    req_gap_pct   <= (mode == 1) ? 52 : (mode == 3) ? 37 : 0;
    rsp_stall_pct <= (mode == 2) ? 52 : (mode == 3) ? 37 : 0;
    eff_cap = (cap == 0) ? 1 : (cap > lkv_pkg::MAX_ENTRIES) ? lkv_pkg::MAX_ENTRIES : int'(cap);
    // a key pool a little larger than the capacity gives both hits and evictions
    repeat (eff_cap + $urandom_range(1, 6)) pool.push_back($urandom());
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 85)
        k = pool[$urandom_range(pool.size() - 1)];
      else
        k = $urandom();
      send($urandom_range(1) ? lkv_pkg::OP_SET : lkv_pkg::OP_GET, k, $urandom());
    end
  endtask

  initial begin
    logic [lkv_pkg::CAP_W-1:0] phase_caps[10];
    phase_caps = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd8, 5'd12, 5'd3, 5'd2, 5'd16};
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    req_ch.valid  = 1'b0;
    req_ch.opcode = lkv_pkg::OP_GET;
    req_ch.key    = '0;
    req_ch.value  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty lookup, key and value extremes, update, miss with a value.
    send(lkv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    send(lkv_pkg::OP_SET, 32'h8000_0000, 32'h7fff_ffff);
    send(lkv_pkg::OP_SET, 32'h7fff_ffff, 32'h8000_0000);
    send(lkv_pkg::OP_SET, 32'h0000_0000, 32'h0000_0000);
    send(lkv_pkg::OP_SET, 32'hffff_ffff, 32'hffff_ffff);
    send(lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
    send(lkv_pkg::OP_GET, 32'h7fff_ffff, 32'h0000_0000);
    send(lkv_pkg::OP_GET, 32'hffff_ffff, 32'h0000_0000);
    send(lkv_pkg::OP_SET, 32'h0000_0000, 32'h1234_5678);
    send(lkv_pkg::OP_GET, 32'h0000_0000, 32'hffff_ffff);
    send(lkv_pkg::OP_GET, 32'h0000_0001, 32'h5555_aaaa);
    // capacity dropped below the filled count: new keys evict, nothing is dropped
    set_capacity(5'd2);
    send(lkv_pkg::OP_SET, 32'h0000_0005, 32'h0000_0055);
    send(lkv_pkg::OP_SET, 32'h0000_0006, 32'h0000_0066);
    send(lkv_pkg::OP_GET, 32'h0000_0005, 32'h0000_0000);
    send(lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
    // zero capacity behaves as one
    set_capacity(5'd0);
    send(lkv_pkg::OP_SET, 32'h0000_0007, 32'h0000_0077);
    send(lkv_pkg::OP_SET, 32'h0000_0008, 32'h0000_0088);
    send(lkv_pkg::OP_GET, 32'h0000_0008, 32'h0000_0000);
    // capacity above the entry count clamps to the entry count
    set_capacity(5'd31);
    for (int i = 0; i < 4; i++)
      send(lkv_pkg::OP_SET, 32'h0000_0100 + i, 32'hcafe_0000 + i);
    send(lkv_pkg::OP_GET, 32'h0000_0006, 32'h0000_0000);

    for (int p = 0; p < 10; p++)
      run_phase(phase_caps[p], p % 4, 140, (p == 4));

    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0)
      $display("lru_key_value_cache test passed");
    else
      $display("lru_key_value_cache test failed");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/lkv_pkg.sv
hw/rtl/lkv_if.sv
hw/rtl/lkv_cell.sv
hw/rtl/lkv_ctl.sv
hw/rtl/lru_key_value_cache.sv
sim/lru_cache_checker.sv
sim/tb_lru_key_value_cache.sv
